FILE: rtl/lsfb_pkg.sv
// Shared types and constants of the LED strip frame buffer and pulse encoder.
package lsfb_pkg;

  // Bits sent for one pixel on the line
  localparam int unsigned PIX_W          = 24;
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned TIME_W         = 15;
  localparam int unsigned LEN_W          = 9;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_STRIP_LENGTH   = 3'd0;
  localparam logic [2:0] CFG_ONE_HIGH_TIME  = 3'd1;
  localparam logic [2:0] CFG_ONE_LOW_TIME   = 3'd2;
  localparam logic [2:0] CFG_ZERO_HIGH_TIME = 3'd3;
  localparam logic [2:0] CFG_ZERO_LOW_TIME  = 3'd4;

  // Register values after reset
  localparam logic [LEN_W-1:0]  RST_STRIP_LENGTH   = 9'd256;
  localparam logic [TIME_W-1:0] RST_ONE_HIGH_TIME  = 15'd8;
  localparam logic [TIME_W-1:0] RST_ONE_LOW_TIME   = 15'd5;
  localparam logic [TIME_W-1:0] RST_ZERO_HIGH_TIME = 15'd4;
  localparam logic [TIME_W-1:0] RST_ZERO_LOW_TIME  = 15'd8;

  // Request functions
  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_FILL  = 3'd2,
    FN_ROT_L = 3'd3,
    FN_ROT_R = 3'd4,
    FN_SHL   = 3'd5,
    FN_SHR   = 3'd6,
    FN_EMIT  = 3'd7
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  position;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
    logic              frame_end;
  } out_item_t;

  // Start of a bulk pass over the store
  typedef struct packed {
    logic             start;
    func_t            op;
    logic [7:0]       pos;
    logic [PIX_W-1:0] color;
  } sweep_req_t;

  // RAM strobes driven by the bulk pass sequencer
  typedef struct packed {
    logic st_we;
    logic st_re;
    logic sc_we;
    logic sc_re;
  } sweep_ram_t;

  // Where the line encoder stands for the next pulse
  typedef struct packed {
    logic       term;
    logic       dark;
    logic [4:0] bsel;
  } emit_info_t;

endpackage

FILE: rtl/lsfb_ram.sv
// Generic simple dual-port RAM with registered read.
module lsfb_ram #(
  parameter int W = 24,
  parameter int D = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lsfb_sweep.sv
// Bulk pass sequencer: clearing after reset, fill, rotate and shift of the store.
module lsfb_sweep #(
  parameter int MAX_PIXELS = 256,
  parameter int AW = 8,
  parameter int SW = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SW-1:0]             len,
  input  lsfb_pkg::sweep_req_t      req,
  input  logic [lsfb_pkg::PIX_W-1:0] st_rdata,
  input  logic [lsfb_pkg::PIX_W-1:0] sc_rdata,
  output logic                      busy,
  output lsfb_pkg::sweep_ram_t      ram,
  output logic [AW-1:0]             st_waddr,
  output logic [lsfb_pkg::PIX_W-1:0] st_wdata,
  output logic [AW-1:0]             st_raddr,
  output logic [AW-1:0]             sc_waddr,
  output logic [lsfb_pkg::PIX_W-1:0] sc_wdata,
  output logic [AW-1:0]             sc_raddr
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_COPY  = 6'b010000,
    ST_MOVE  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [SW-1:0]              x_r, x_nxt;
  logic [SW-1:0]              p_r, p_nxt;
  logic [SW-1:0]              r_r, r_nxt;
  logic [2:0]                 k_r, k_nxt;
  lsfb_pkg::func_t            op_r, op_nxt;
  logic [7:0]                 pos_r, pos_nxt;
  logic [lsfb_pkg::PIX_W-1:0] color_r, color_nxt;

  // delayed write of a read-modify-write pass
  logic                       wv_r, wv_nxt;
  logic                       wsc_r, wsc_nxt;
  logic                       wblank_r, wblank_nxt;
  logic [AW-1:0]              wa_r, wa_nxt;

  logic [SW:0]                mod_t, mod_red, len_x;
  logic [SW-1:0]              r_step, p_wrap, pos_sw, shr_src;
  logic [SW-1:0]              src;
  logic                       src_ok;

  // one restoring remainder step per cycle: amount modulo length
  assign len_x   = {1'b0, len};
  assign mod_t   = {r_r, pos_r[k_r]};
  assign mod_red = (mod_t >= len_x) ? (mod_t - len_x) : mod_t;
  assign r_step  = mod_red[SW-1:0];

  assign pos_sw  = SW'(pos_r);
  assign shr_src = x_r - pos_sw;
  assign p_wrap  = ((p_r + SW'(1)) == len) ? '0 : (p_r + SW'(1));

  // source entry of the scratch copy for the current target
  always_comb begin
    src    = p_r;
    src_ok = 1'b1;
    unique case (op_r)
      lsfb_pkg::FN_SHL: begin
        src_ok = (p_r < len);
      end
      lsfb_pkg::FN_SHR: begin
        src    = shr_src;
        src_ok = (x_r >= pos_sw);
      end
      default: begin
        src    = p_r;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE) || wv_r;

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    p_nxt      = p_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    color_nxt  = color_r;
    wv_nxt     = 1'b0;
    wsc_nxt    = wsc_r;
    wblank_nxt = wblank_r;
    wa_nxt     = wa_r;
    ram        = '0;
    st_waddr   = '0;
    st_wdata   = '0;
    st_raddr   = '0;
    sc_waddr   = '0;
    sc_wdata   = '0;
    sc_raddr   = '0;

    // write-back half of the copy and move passes
    if (wv_r) begin
      if (wsc_r) begin
        ram.sc_we = 1'b1;
        sc_waddr  = wa_r;
        sc_wdata  = st_rdata;
      end else begin
        ram.st_we = 1'b1;
        st_waddr  = wa_r;
        st_wdata  = wblank_r ? '0 : sc_rdata;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram.st_we = 1'b1;
        st_waddr  = x_r[AW-1:0];
        st_wdata  = '0;
        if (x_r == SW'(MAX_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
          x_nxt     = '0;
        end else begin
          x_nxt = x_r + SW'(1);
        end
      end
      ST_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          pos_nxt   = req.pos;
          color_nxt = req.color;
          x_nxt     = '0;
          r_nxt     = '0;
          k_nxt     = 3'd7;
          p_nxt     = SW'(req.pos);
          priority case (req.op)
            lsfb_pkg::FN_FILL:  state_nxt = ST_FILL;
            lsfb_pkg::FN_ROT_L: state_nxt = ST_MOD;
            lsfb_pkg::FN_ROT_R: state_nxt = ST_MOD;
            default:            state_nxt = ST_COPY;
          endcase
        end
      end
      ST_FILL: begin
        ram.st_we = 1'b1;
        st_waddr  = x_r[AW-1:0];
        st_wdata  = color_r;
        if (x_r == len - SW'(1)) begin
          state_nxt = ST_IDLE;
          x_nxt     = '0;
        end else begin
          x_nxt = x_r + SW'(1);
        end
      end
      ST_MOD: begin
        r_nxt = r_step;
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd0) begin
          state_nxt = ST_COPY;
          x_nxt     = '0;
          if (op_r == lsfb_pkg::FN_ROT_L) begin
            p_nxt = r_step;
          end else begin
            p_nxt = (r_step == '0) ? '0 : (len - r_step);
          end
        end
      end
      ST_COPY: begin
        // the final visit with x at len lets the last scratch write land
        if (x_r < len) begin
          ram.st_re = 1'b1;
          st_raddr  = x_r[AW-1:0];
          wv_nxt    = 1'b1;
          wsc_nxt   = 1'b1;
          wa_nxt    = x_r[AW-1:0];
          x_nxt     = x_r + SW'(1);
        end else begin
          state_nxt = ST_MOVE;
          x_nxt     = '0;
        end
      end
      ST_MOVE: begin
        ram.sc_re  = src_ok;
        sc_raddr   = src[AW-1:0];
        wv_nxt     = 1'b1;
        wsc_nxt    = 1'b0;
        wblank_nxt = !src_ok;
        wa_nxt     = x_r[AW-1:0];
        if (op_r == lsfb_pkg::FN_SHL) begin
          p_nxt = p_r + SW'(1);
        end else begin
          p_nxt = p_wrap;
        end
        if (x_r == len - SW'(1)) begin
          state_nxt = ST_IDLE;
          x_nxt     = '0;
        end else begin
          x_nxt = x_r + SW'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        x_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      x_r     <= '0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      wv_r    <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    r_r      <= r_nxt;
    k_r      <= k_nxt;
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    color_r  <= color_nxt;
    wsc_r    <= wsc_nxt;
    wblank_r <= wblank_nxt;
    wa_r     <= wa_nxt;
  end

endmodule

FILE: rtl/lsfb_emit.sv
// Line encoder position: frame slot and wire bit of the next pulse.
module lsfb_emit #(
  parameter int AW = 8,
  parameter int SW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SW-1:0]        len,
  input  logic                 step,
  output lsfb_pkg::emit_info_t info,
  output logic [AW-1:0]        addr
);

  logic [SW-1:0] slot_r, slot_nxt;
  logic [4:0]    bit_r, bit_nxt;
  logic [SW-1:0] slot_m1;

  // colour bit sent at wire position b: G7..G0, R7..R0, B7..B0
  function automatic logic [4:0] wire_bit(input logic [4:0] b);
    logic [4:0] idx;
    if (b < 5'd8) begin
      idx = 5'd15 - b;
    end else if (b < 5'd16) begin
      idx = 5'd31 - b;
    end else begin
      idx = 5'd23 - b;
    end
    return idx;
  endfunction

  assign info.term = (slot_r > len);
  assign info.dark = (slot_r == '0);
  assign info.bsel = wire_bit(bit_r);
  assign slot_m1   = slot_r - SW'(1);
  assign addr      = slot_m1[AW-1:0];

  // advance bit, then slot; terminator restarts the frame
  always_comb begin
    slot_nxt = slot_r;
    bit_nxt  = bit_r;
    if (step) begin
      if (info.term) begin
        slot_nxt = '0;
        bit_nxt  = '0;
      end else if (bit_r == 5'(lsfb_pkg::BITS_PER_PIXEL - 1)) begin
        bit_nxt  = '0;
        slot_nxt = slot_r + SW'(1);
      end else begin
        bit_nxt = bit_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      bit_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      bit_r  <= bit_nxt;
    end
  end

endmodule

FILE: rtl/led_strip_frame_buffer_encoder_unit.sv
// Top level of the LED strip frame buffer and pulse encoder.
//
// Requests come in on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a side is moved when valid is high and stall
// is low. Write, read and emit requests go back to back, one per cycle while
// in_stall is low; the store is read at the edge that takes a read or emit
// request, and its result then passes the read stage and the output register.
// Fill, shift and rotate keep in_stall high while they run: these passes
// walk the store one entry a cycle through its single write port, rotate and
// shift via a scratch copy, and rotate first reduces the amount modulo L, L
// being the clamped strip length.
// After reset the store is cleared to black, one entry a cycle, with in_stall
// high; registers may be written meanwhile. If the receiver stalls, one result
// waits in the output register and one in the read stage, then in_stall rises
// until the output drains. Registers are written through cfg_we/cfg_index/
// cfg_data while idle, a rule for the user that the block does not enforce.
module led_strip_frame_buffer_encoder_unit #(
  parameter int MAX_PIXELS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsfb_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsfb_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [14:0]          cfg_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SW = $clog2(MAX_PIXELS + 256);

  // configuration registers
  logic [lsfb_pkg::LEN_W-1:0]  strip_length_r;
  logic [lsfb_pkg::TIME_W-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_length_r <= lsfb_pkg::RST_STRIP_LENGTH;
      one_high_r     <= lsfb_pkg::RST_ONE_HIGH_TIME;
      one_low_r      <= lsfb_pkg::RST_ONE_LOW_TIME;
      zero_high_r    <= lsfb_pkg::RST_ZERO_HIGH_TIME;
      zero_low_r     <= lsfb_pkg::RST_ZERO_LOW_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfb_pkg::CFG_STRIP_LENGTH:   strip_length_r <= cfg_data[lsfb_pkg::LEN_W-1:0];
        lsfb_pkg::CFG_ONE_HIGH_TIME:  one_high_r     <= cfg_data;
        lsfb_pkg::CFG_ONE_LOW_TIME:   one_low_r      <= cfg_data;
        lsfb_pkg::CFG_ZERO_HIGH_TIME: zero_high_r    <= cfg_data;
        lsfb_pkg::CFG_ZERO_LOW_TIME:  zero_low_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // strip length clamped to 1..MAX_PIXELS
  logic [SW-1:0] sl_ext, len;
  assign sl_ext = SW'(strip_length_r);
  assign len    = (sl_ext == '0) ? SW'(1) :
                  (sl_ext > SW'(MAX_PIXELS)) ? SW'(MAX_PIXELS) : sl_ext;

  // request decode
  logic                       acc, adv;
  logic                       sw_busy;
  logic                       rd_vld_r, rd_vld_nxt;
  logic                       out_vld_r, out_vld_nxt;
  logic [SW-1:0]              pos_sw;
  logic                       pos_ok;
  logic [AW-1:0]              pos_addr;
  logic [lsfb_pkg::PIX_W-1:0] color;
  logic                       is_wr, is_rd, is_emit;
  logic                       item_st_we, item_st_re;

  assign adv      = rd_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = sw_busy || (rd_vld_r && !adv);
  assign acc      = in_valid && !in_stall;

  assign pos_sw   = SW'(in_data.position);
  assign pos_ok   = (pos_sw < len);
  assign pos_addr = pos_sw[AW-1:0];
  assign color    = {in_data.red_in, in_data.green_in, in_data.blue_in};
  assign is_wr    = (in_data.func == lsfb_pkg::FN_WRITE);
  assign is_rd    = (in_data.func == lsfb_pkg::FN_READ);
  assign is_emit  = (in_data.func == lsfb_pkg::FN_EMIT);

  // bulk pass hand-off
  lsfb_pkg::sweep_req_t       sw_req;
  lsfb_pkg::sweep_ram_t       sw_ram;
  logic [AW-1:0]              sw_st_waddr, sw_st_raddr, sc_waddr, sc_raddr;
  logic [lsfb_pkg::PIX_W-1:0] sw_st_wdata, sc_wdata, st_rdata, sc_rdata;

  assign sw_req.start = acc && !is_wr && !is_rd && !is_emit;
  assign sw_req.op    = in_data.func;
  assign sw_req.pos   = in_data.position;
  assign sw_req.color = color;

  lsfb_sweep #(
    .MAX_PIXELS (MAX_PIXELS),
    .AW         (AW),
    .SW         (SW)
  ) u_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .len      (len),
    .req      (sw_req),
    .st_rdata (st_rdata),
    .sc_rdata (sc_rdata),
    .busy     (sw_busy),
    .ram      (sw_ram),
    .st_waddr (sw_st_waddr),
    .st_wdata (sw_st_wdata),
    .st_raddr (sw_st_raddr),
    .sc_waddr (sc_waddr),
    .sc_wdata (sc_wdata),
    .sc_raddr (sc_raddr)
  );

  // line encoder position
  lsfb_pkg::emit_info_t em_info;
  logic [AW-1:0]        em_addr;

  lsfb_emit #(
    .AW (AW),
    .SW (SW)
  ) u_emit (
    .clk   (clk),
    .rst_n (rst_n),
    .len   (len),
    .step  (acc && is_emit),
    .info  (em_info),
    .addr  (em_addr)
  );

  // store port arbitration: passes own the store while busy
  logic                       st_we, st_re;
  logic [AW-1:0]              st_waddr, st_raddr;
  logic [lsfb_pkg::PIX_W-1:0] st_wdata;

  assign item_st_we = acc && is_wr && pos_ok;
  assign item_st_re = acc && ((is_rd && pos_ok) ||
                              (is_emit && !em_info.term && !em_info.dark));

  assign st_we    = item_st_we || sw_ram.st_we;
  assign st_waddr = sw_ram.st_we ? sw_st_waddr : pos_addr;
  assign st_wdata = sw_ram.st_we ? sw_st_wdata : color;
  assign st_re    = item_st_re || sw_ram.st_re;
  assign st_raddr = sw_ram.st_re ? sw_st_raddr : (is_emit ? em_addr : pos_addr);

  lsfb_ram #(
    .W (lsfb_pkg::PIX_W),
    .D (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lsfb_ram #(
    .W (lsfb_pkg::PIX_W),
    .D (MAX_PIXELS)
  ) u_scratch (
    .clk   (clk),
    .we    (sw_ram.sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .re    (sw_ram.sc_re),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  // read stage: waits for the store data
  logic       s1_kind_r, s1_black_r, s1_term_r;
  logic [4:0] s1_bsel_r;
  logic       acc_res;

  assign acc_res    = acc && (is_rd || is_emit);
  assign rd_vld_nxt = acc_res ? 1'b1 : (adv ? 1'b0 : rd_vld_r);

  always_ff @(posedge clk) begin
    if (acc_res) begin
      s1_kind_r  <= is_emit;
      s1_black_r <= is_emit ? em_info.dark : !pos_ok;
      s1_term_r  <= is_emit && em_info.term;
      s1_bsel_r  <= em_info.bsel;
    end
  end

  // result formatting
  lsfb_pkg::out_item_t res, out_r;
  logic                bitv;

  assign bitv = !s1_black_r && st_rdata[s1_bsel_r];

  always_comb begin
    res = '0;
    if (!s1_kind_r) begin
      if (!s1_black_r) begin
        res.red_out   = st_rdata[23:16];
        res.green_out = st_rdata[15:8];
        res.blue_out  = st_rdata[7:0];
      end
    end else begin
      res.kind = 1'b1;
      if (s1_term_r) begin
        res.frame_end = 1'b1;
      end else begin
        res.high_time = bitv ? one_high_r : zero_high_r;
        res.low_time  = bitv ? one_low_r : zero_low_r;
      end
    end
  end

  // output register
  assign out_vld_nxt = adv ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // a waiting read result is not lost while the output is blocked
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && out_vld_r && out_stall) |=> rd_vld_r)
    else $error("read stage dropped a result while output stalled");

  // requests never touch the store while a pass owns it
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !((item_st_re || item_st_we) && (sw_ram.st_we || sw_ram.st_re)))
    else $error("request access collides with a bulk pass");

  // terminator pulse carries no timing
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.frame_end) |->
      (out_r.kind && out_r.high_time == '0 && out_r.low_time == '0))
    else $error("terminator pulse with non-zero timing");

  // a pass is only started from idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sw_req.start |-> !sw_busy)
    else $error("bulk pass started while busy");

endmodule

FILE: dv/led_strip_frame_buffer_encoder_unit_tb.sv
// Self-checking testbench for the LED strip frame buffer and pulse encoder.
module led_strip_frame_buffer_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PIX        = 256;
  localparam int unsigned SETTLE_CYCLES  = 2 * MAX_PIX + 48;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS    = 135;

  // Mirror of the pixel store, emit position and timing registers
  class strip_mirror;
    logic [lsfb_pkg::PIX_W-1:0]  pixels [MAX_PIX];
    logic [lsfb_pkg::LEN_W-1:0]  length_reg;
    logic [lsfb_pkg::TIME_W-1:0] one_hi, one_lo, zero_hi, zero_lo;
    int unsigned                 slot_idx, bit_idx;
    lsfb_pkg::out_item_t         due_results [$];
    int unsigned                 errors, reads, pulses, frames, passes;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      length_reg = lsfb_pkg::RST_STRIP_LENGTH;
      one_hi     = lsfb_pkg::RST_ONE_HIGH_TIME;
      one_lo     = lsfb_pkg::RST_ONE_LOW_TIME;
      zero_hi    = lsfb_pkg::RST_ZERO_HIGH_TIME;
      zero_lo    = lsfb_pkg::RST_ZERO_LOW_TIME;
      slot_idx   = 0;
      bit_idx    = 0;
      errors     = 0;
      reads      = 0;
      pulses     = 0;
      frames     = 0;
      passes     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] val);
      case (idx)
        lsfb_pkg::CFG_STRIP_LENGTH:   length_reg = val[lsfb_pkg::LEN_W-1:0];
        lsfb_pkg::CFG_ONE_HIGH_TIME:  one_hi = val;
        lsfb_pkg::CFG_ONE_LOW_TIME:   one_lo = val;
        lsfb_pkg::CFG_ZERO_HIGH_TIME: zero_hi = val;
        lsfb_pkg::CFG_ZERO_LOW_TIME:  zero_lo = val;
        default: ;
      endcase
    endfunction

    // Strip length clamped to 1..MAX_PIX
    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_PIX) return MAX_PIX;
      return 32'(length_reg);
    endfunction

    function int unsigned count();
      return due_results.size();
    endfunction

    // Apply one accepted request and queue the result it causes
    function void take_request(lsfb_pkg::in_item_t rq);
      logic [lsfb_pkg::PIX_W-1:0] snap [MAX_PIX];
      logic [lsfb_pkg::PIX_W-1:0] colour, c;
      lsfb_pkg::out_item_t        res;
      int unsigned                len, n, src, wb;
      len    = span();
      colour = {rq.red_in, rq.green_in, rq.blue_in};
      res    = '0;
      case (rq.func)
        lsfb_pkg::FN_WRITE: begin
          if (rq.position < len) pixels[rq.position] = colour;
        end
        lsfb_pkg::FN_READ: begin
          c = (rq.position < len) ? pixels[rq.position] : '0;
          res.red_out   = c[23:16];
          res.green_out = c[15:8];
          res.blue_out  = c[7:0];
          due_results.push_back(res);
          reads++;
        end
        lsfb_pkg::FN_FILL: begin
          for (int x = 0; x < len; x++) pixels[x] = colour;
          passes++;
        end
        lsfb_pkg::FN_ROT_L, lsfb_pkg::FN_ROT_R: begin
          n    = rq.position % len;
          snap = pixels;
          for (int x = 0; x < len; x++) begin
            src = (rq.func == lsfb_pkg::FN_ROT_L) ? (x + n) % len : (x + len - n) % len;
            pixels[x] = snap[src];
          end
          passes++;
        end
        lsfb_pkg::FN_SHL, lsfb_pkg::FN_SHR: begin
          snap = pixels;
          for (int x = 0; x < len; x++) begin
            if (rq.func == lsfb_pkg::FN_SHL)
              pixels[x] = (x + rq.position < len) ? snap[x + rq.position] : '0;
            else
              pixels[x] = (x >= rq.position) ? snap[x - rq.position] : '0;
          end
          passes++;
        end
        default: begin
          res.kind = 1'b1;
          if (slot_idx > len) begin
            // terminator, also when the length was cut below the emit slot
            res.frame_end = 1'b1;
            slot_idx = 0;
            bit_idx  = 0;
            frames++;
          end else begin
            if (bit_idx >= lsfb_pkg::BITS_PER_PIXEL) bit_idx = 0;
            c = (slot_idx == 0) ? '0 : pixels[(slot_idx - 1) % MAX_PIX];
            // wire order G7..G0, R7..R0, B7..B0
            if (bit_idx < 8)       wb = 15 - bit_idx;
            else if (bit_idx < 16) wb = 23 - (bit_idx - 8);
            else                   wb = 7 - (bit_idx - 16);
            res.high_time = c[wb] ? one_hi : zero_hi;
            res.low_time  = c[wb] ? one_lo : zero_lo;
            bit_idx++;
            if (bit_idx >= lsfb_pkg::BITS_PER_PIXEL) begin
              bit_idx = 0;
              slot_idx++;
            end
            pulses++;
          end
          due_results.push_back(res);
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one result with the oldest pending one
    function void match_result(lsfb_pkg::out_item_t got);
      lsfb_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
        return;
      end
      want = due_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("red_out", 32'(want.red_out), 32'(got.red_out));
      check_field("green_out", 32'(want.green_out), 32'(got.green_out));
      check_field("blue_out", 32'(want.blue_out), 32'(got.blue_out));
      check_field("high_time", 32'(want.high_time), 32'(got.high_time));
      check_field("low_time", 32'(want.low_time), 32'(got.low_time));
      check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lsfb_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  lsfb_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [14:0]         cfg_data;

  strip_mirror mirror;
  bit          no_idle      = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_active  = 1'b0;
  int unsigned sent         = 0;
  int unsigned settings     = 0;

  led_strip_frame_buffer_encoder_unit #(.MAX_PIXELS(MAX_PIX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) mirror.match_result(out_data);
  end

  // Receiver: random stalls, an occasional long hold-off on request
  initial begin : result_sink
    int unsigned run;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall   <= 1'b1;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_active  = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        run = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(15, 50);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL led_strip_frame_buffer_encoder_unit");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lsfb_pkg::in_item_t make_request(lsfb_pkg::func_t f, logic [7:0] pos,
                                                      logic [23:0] rgb);
    lsfb_pkg::in_item_t rq;
    rq.func     = f;
    rq.position = pos;
    {rq.red_in, rq.green_in, rq.blue_in} = rgb;
    return rq;
  endfunction

  // Weighted mix; indexes mostly inside the strip, move amounts often small
  function automatic lsfb_pkg::in_item_t random_request(int unsigned len);
    lsfb_pkg::in_item_t rq;
    int unsigned        w;
    rq.position = 8'($urandom_range(0, 255));
    rq.red_in   = 8'($urandom_range(0, 255));
    rq.green_in = 8'($urandom_range(0, 255));
    rq.blue_in  = 8'($urandom_range(0, 255));
    w = $urandom_range(0, 99);
    if (w < 24)      rq.func = lsfb_pkg::FN_WRITE;
    else if (w < 44) rq.func = lsfb_pkg::FN_READ;
    else if (w < 78) rq.func = lsfb_pkg::FN_EMIT;
    else if (w < 82) rq.func = lsfb_pkg::FN_FILL;
    else if (w < 86) rq.func = lsfb_pkg::FN_ROT_L;
    else if (w < 90) rq.func = lsfb_pkg::FN_ROT_R;
    else if (w < 95) rq.func = lsfb_pkg::FN_SHL;
    else             rq.func = lsfb_pkg::FN_SHR;
    if (rq.func == lsfb_pkg::FN_WRITE || rq.func == lsfb_pkg::FN_READ) begin
      if ($urandom_range(0, 99) < 85) rq.position = 8'($urandom_range(0, len - 1));
    end else if (rq.func != lsfb_pkg::FN_EMIT && $urandom_range(0, 99) < 50) begin
      rq.position = 8'($urandom_range(0, (len < 255) ? len + 1 : 255));
    end
    return rq;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input lsfb_pkg::in_item_t rq);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.take_request(rq);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every pending result, then let a pass finish
  task automatic quiesce(input int unsigned settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.count() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_regs(input logic [14:0] v_len, v_oh, v_ol, v_zh, v_zl);
    logic [14:0] vals [5];
    logic [2:0]  idxs [5];
    vals = '{v_len, v_oh, v_ol, v_zh, v_zl};
    idxs = '{lsfb_pkg::CFG_STRIP_LENGTH, lsfb_pkg::CFG_ONE_HIGH_TIME,
             lsfb_pkg::CFG_ONE_LOW_TIME, lsfb_pkg::CFG_ZERO_HIGH_TIME,
             lsfb_pkg::CFG_ZERO_LOW_TIME};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      mirror.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [14:0] rand_time();
    return 15'($urandom_range(0, 32767));
  endfunction

  function automatic logic [14:0] rand_length();
    return 15'($urandom_range(1, 16));
  endfunction

  initial begin : stimulus
    int unsigned        n;
    lsfb_pkg::in_item_t rq;
    mirror    = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes at reset length, then a short strip
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd0, 24'hff00a5));
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd255, 24'hffffff));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd0, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd255, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_EMIT, 8'd0, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_EMIT, 8'd0, 24'h000000));
    quiesce(SETTLE_CYCLES);
    write_regs(15'd4, 15'h7fff, 15'd0, 15'd0, 15'h7fff);
    // index past the strip: write dropped, read black
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd4, 24'h123456));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd4, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd255, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_FILL, 8'd0, 24'h00ff00));
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd0, 24'h0000ff));
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd3, 24'hff0000));
    // rotate amount past the length wraps
    send_request(make_request(lsfb_pkg::FN_ROT_L, 8'd5, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd0, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_ROT_R, 8'd3, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd0, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_SHL, 8'd1, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd3, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_WRITE, 8'd1, 24'h5a5a5a));
    send_request(make_request(lsfb_pkg::FN_SHR, 8'd2, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd3, 24'h000000));
    // shift by the whole length clears the strip
    send_request(make_request(lsfb_pkg::FN_SHR, 8'd4, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_READ, 8'd1, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_EMIT, 8'd0, 24'h000000));
    send_request(make_request(lsfb_pkg::FN_EMIT, 8'd0, 24'h000000));
    quiesce(SETTLE_CYCLES);
    // pixels beyond the short strip were kept
    write_regs(15'd256, lsfb_pkg::RST_ONE_HIGH_TIME, lsfb_pkg::RST_ONE_LOW_TIME,
               lsfb_pkg::RST_ZERO_HIGH_TIME, lsfb_pkg::RST_ZERO_LOW_TIME);
    send_request(make_request(lsfb_pkg::FN_READ, 8'd255, 24'h000000));

    // Random phases over several register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce(SETTLE_CYCLES);
      n       = PHASE_ITEMS;
      no_idle = 1'b0;
      case (p)
        0: write_regs(15'd1, 15'h7fff, 15'd0, 15'd0, 15'h7fff);
        1: write_regs(15'd0, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        2: begin
          // length field saturated, clamps to the full store
          write_regs(15'h7fff, rand_time(), rand_time(), rand_time(), rand_time());
          n = 60;
        end
        4: begin
          write_regs(rand_length(), rand_time(), rand_time(), rand_time(), rand_time());
          no_idle = 1'b1;
        end
        6: begin
          write_regs(15'd30, rand_time(), rand_time(), rand_time(), rand_time());
          n = 0;
          // long receiver hold-off while the sender keeps pushing emits
          hold_off_req = 1'b1;
          while (!hold_active) @(posedge clk);
          no_idle = 1'b1;
          repeat (60) begin
            rq      = random_request(mirror.span());
            rq.func = lsfb_pkg::FN_EMIT;
            send_request(rq);
          end
          no_idle = 1'b0;
          repeat (140) begin
            rq      = random_request(mirror.span());
            rq.func = lsfb_pkg::FN_EMIT;
            send_request(rq);
          end
          quiesce(0);
        end
        // shorter than the emit slot reached above: next emit ends the frame
        7: write_regs(15'd3, rand_time(), rand_time(), rand_time(), rand_time());
        default: write_regs(rand_length(), rand_time(), rand_time(), rand_time(),
                            rand_time());
      endcase
      repeat (n) send_request(random_request(mirror.span()));
    end

    quiesce(SETTLE_CYCLES);
    $display("Covered %0d requests: %0d reads, %0d bit pulses, %0d frame ends, %0d store passes",
             sent, mirror.reads, mirror.pulses, mirror.frames, mirror.passes);
    $display("Register settings applied: %0d, lengths 1 to full store, times 0 to max",
             settings);
    if (mirror.errors == 0 && mirror.count() == 0)
      $display("PASS led_strip_frame_buffer_encoder_unit");
    else
      $display("FAIL led_strip_frame_buffer_encoder_unit");
    $finish;
  end

endmodule
